@@ src/bft_pkg.sv @@
package bft_pkg;

  localparam int unsigned DefNumSets = 256;
  localparam int unsigned DefNumWays = 4;

  localparam logic [31:0] LifetimeReset = 32'd1800;
  localparam logic [31:0] IdleReset     = 32'd60;

  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    StCreated = 3'd0,
    StFwd     = 3'd1,
    StRev     = 3'd2,
    StFull    = 3'd3,
    StExpired = 3'd4,
    StLive    = 3'd5,
    StEmpty   = 3'd6
  } status_e;

  typedef enum logic {
    OpPacket = 1'b0,
    OpExpire = 1'b1
  } opcode_e;

  typedef enum logic {
    RegLifetime = 1'b0,
    RegIdle     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  proto;
    logic [15:0] pkt_bytes;
    logic [31:0] now_time;
    logic [9:0]  entry_index;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] flow_src_addr;
    logic [31:0] flow_dst_addr;
    logic [15:0] flow_src_port;
    logic [15:0] flow_dst_port;
    logic [7:0]  flow_proto;
    logic [31:0] first_seen;
    logic [31:0] last_seen;
    logic [31:0] fwd_packets;
    logic [31:0] rev_packets;
    logic [47:0] fwd_bytes;
    logic [47:0] rev_bytes;
  } result_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [7:0]  proto;
    logic [31:0] start_stamp;
    logic [31:0] last_stamp;
    logic [31:0] fwd_pkts;
    logic [31:0] rev_pkts;
    logic [47:0] fwd_bytes;
    logic [47:0] rev_bytes;
  } entry_t;

endpackage

@@ src/bidirectional_flow_table.sv @@
// bidirectional flow table: set-associative five-tuple flow accounting
// input channel (in_valid_i/in_ready_o/in_i) takes one beat per item: a
// packet update or an expiry check of one entry; output channel
// (out_valid_o/out_ready_i/out_o) gives exactly one result beat per item
// a packet beat first folds its tuple into a set number; with a power of
// two set count the set number is the low bits of the fold, otherwise a
// reciprocal multiply and a correction step compute it. the ways of the
// set are then read one at a time through the single read port of the
// flow memory up to the first match; an expiry item reads its one entry,
// and an out-of-range entry index gives an empty result without a read
// the block takes one item at a time; in_ready_o is low while an item is
// in work. the output register holds a finished result while the receiver
// stalls and the next item may already be accepted meanwhile; a second
// finished result waits with in_ready_o low until the first goes
// after reset a sweep clears the valid bits of all NUM_SETS*NUM_WAYS
// entries, during which no item is accepted; config writes are taken always
// config: cfg_we_i writes cfg_data_i into the register cfg_addr_i selects
module bidirectional_flow_table #(
  parameter int unsigned NUM_SETS = bft_pkg::DefNumSets,
  parameter int unsigned NUM_WAYS = bft_pkg::DefNumWays
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bft_pkg::item_t   in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bft_pkg::result_t out_o
);
  import bft_pkg::*;

  localparam int unsigned NumEntries = NUM_SETS * NUM_WAYS;
  localparam int unsigned AddrW = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int unsigned SetW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WayW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam bit          IsPow2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
  // reciprocal of the set count, exact for every 32-bit fold
  localparam int unsigned RecipL = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 0;
  localparam logic [63:0] RecipM = ((64'd1 << (32 + RecipL)) + 64'(NUM_SETS) - 64'd1)
                                   / 64'(NUM_SETS);

  typedef enum logic [7:0] {
    SClear = 8'b0000_0001,
    SIdle  = 8'b0000_0010,
    SHash  = 8'b0000_0100,
    SBase  = 8'b0000_1000,
    SWait  = 8'b0001_0000,
    SCmp   = 8'b0010_0000,
    SChk   = 8'b0100_0000,
    SDone  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // flow store and its valid bits
  entry_t mem_q [NumEntries];
  logic   vmem_q [NumEntries];
  entry_t rd_q;
  logic   rd_vld_q;

  logic             mem_we, vmem_we, vmem_wdata;
  logic [AddrW-1:0] mem_waddr, vmem_waddr;
  entry_t           mem_wdata;

  logic [31:0] lifetime_q, idle_q;
  item_t       item_q;
  logic [AddrW-1:0] addr_q, addr_d, clr_q, clr_d, free_q, free_d;
  logic        have_free_q, have_free_d;
  logic [WayW-1:0] way_q, way_d;
  logic [31:0] hash_q, hash_d;
  logic [SetW-1:0] rem_q, rem_d;
  logic        step_q, step_d;
  logic [64:0] prod_q, prod_d;
  result_t     res_q, res_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  // symmetric fold of the incoming tuple
  logic [31:0] fold_x, fold_h;
  assign fold_x = (in_i.src_addr ^ in_i.dst_addr)
                ^ {16'd0, in_i.src_port ^ in_i.dst_port} ^ {24'd0, in_i.proto};
  assign fold_h = fold_x ^ {16'd0, fold_x[31:16]};

  // quotient of the fold by the set count, from the reciprocal product
  logic [31:0] quot;
  assign quot = 32'(prod_q >> (32 + RecipL));

  // tuple compare of the entry just read
  logic [31:0] fwd_ports, rev_ports;
  logic        match_fwd, match_rev;
  assign fwd_ports = {item_q.src_port, item_q.dst_port};
  assign rev_ports = {item_q.dst_port, item_q.src_port};
  assign match_fwd = rd_vld_q && rd_q.proto == item_q.proto &&
                     rd_q.src_addr == item_q.src_addr &&
                     rd_q.dst_addr == item_q.dst_addr && rd_q.ports == fwd_ports;
  assign match_rev = rd_vld_q && rd_q.proto == item_q.proto &&
                     rd_q.src_addr == item_q.dst_addr &&
                     rd_q.dst_addr == item_q.src_addr && rd_q.ports == rev_ports;

  // saturating update, one direction at a time
  logic [31:0] pkt_sel, pkt_inc;
  logic [47:0] byte_sel, byte_sum;
  logic [48:0] byte_raw;
  always_comb begin
    pkt_sel  = match_fwd ? rd_q.fwd_pkts : rd_q.rev_pkts;
    byte_sel = match_fwd ? rd_q.fwd_bytes : rd_q.rev_bytes;
    pkt_inc  = (pkt_sel == Max32) ? pkt_sel : pkt_sel + 32'd1;
    byte_raw = {1'b0, byte_sel} + {33'd0, item_q.pkt_bytes};
    byte_sum = (byte_raw > {1'b0, Max48}) ? Max48 : byte_raw[47:0];
  end

  logic expired;
  assign expired = ((rd_q.last_stamp - rd_q.start_stamp) >= lifetime_q) ||
                   ((item_q.now_time - rd_q.last_stamp) >= idle_q);

  function automatic result_t to_result(logic [2:0] st, entry_t e);
    result_t r;
    r.status        = st;
    r.flow_src_addr = e.src_addr;
    r.flow_dst_addr = e.dst_addr;
    r.flow_src_port = e.ports[31:16];
    r.flow_dst_port = e.ports[15:0];
    r.flow_proto    = e.proto;
    r.first_seen    = e.start_stamp;
    r.last_seen     = e.last_stamp;
    r.fwd_packets   = e.fwd_pkts;
    r.rev_packets   = e.rev_pkts;
    r.fwd_bytes     = e.fwd_bytes;
    r.rev_bytes     = e.rev_bytes;
    return r;
  endfunction

  function automatic result_t zero_result(logic [2:0] st);
    result_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  entry_t upd, fresh;
  always_comb begin
    upd            = rd_q;
    upd.last_stamp = item_q.now_time;
    if (match_fwd) begin
      upd.fwd_pkts  = pkt_inc;
      upd.fwd_bytes = byte_sum;
    end else begin
      upd.rev_pkts  = pkt_inc;
      upd.rev_bytes = byte_sum;
    end
    fresh.src_addr    = item_q.src_addr;
    fresh.dst_addr    = item_q.dst_addr;
    fresh.ports       = fwd_ports;
    fresh.proto       = item_q.proto;
    fresh.start_stamp = item_q.now_time;
    fresh.last_stamp  = item_q.now_time;
    fresh.fwd_pkts    = 32'd1;
    fresh.rev_pkts    = 32'd0;
    fresh.fwd_bytes   = {32'd0, item_q.pkt_bytes};
    fresh.rev_bytes   = 48'd0;
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    free_d      = free_q;
    have_free_d = have_free_q;
    way_d       = way_q;
    hash_d      = hash_q;
    rem_d       = rem_q;
    step_d      = step_q;
    prod_d      = prod_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = upd;
    vmem_we     = 1'b0;
    vmem_waddr  = addr_q;
    vmem_wdata  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      SClear: begin
        vmem_we    = 1'b1;
        vmem_waddr = clr_q;
        clr_d      = clr_q + AddrW'(1);
        if (clr_q == AddrW'(NumEntries - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          have_free_d = 1'b0;
          way_d       = '0;
          if (in_i.opcode == OpExpire) begin
            if ({22'd0, in_i.entry_index} >= 32'(NumEntries)) begin
              res_d   = zero_result(StEmpty);
              state_d = SDone;
            end else begin
              addr_d  = AddrW'(in_i.entry_index);
              state_d = SWait;
            end
          end else if (IsPow2) begin
            rem_d   = SetW'(fold_h & 32'(NUM_SETS - 1));
            state_d = SBase;
          end else begin
            hash_d  = fold_h;
            step_d  = 1'b0;
            state_d = SHash;
          end
        end
      end
      SHash: begin
        // reciprocal product first, then fold minus quotient times set count
        if (!step_q) begin
          prod_d = hash_q * RecipM[32:0];
          step_d = 1'b1;
        end else begin
          rem_d   = SetW'(hash_q - quot * 32'(NUM_SETS));
          state_d = SBase;
        end
      end
      SBase: begin
        addr_d  = AddrW'(AddrW'(rem_q) * AddrW'(NUM_WAYS));
        state_d = SWait;
      end
      SWait: begin
        state_d = (item_q.opcode == OpExpire) ? SChk : SCmp;
      end
      SChk: begin
        if (!rd_vld_q) begin
          res_d = zero_result(StEmpty);
        end else if (expired) begin
          res_d   = to_result(StExpired, rd_q);
          vmem_we = 1'b1;
        end else begin
          res_d = to_result(StLive, rd_q);
        end
        state_d = SDone;
      end
      SCmp: begin
        if (match_fwd || match_rev) begin
          mem_we  = 1'b1;
          res_d   = to_result(match_fwd ? StFwd : StRev, upd);
          state_d = SDone;
        end else begin
          if (!rd_vld_q && !have_free_q) begin
            have_free_d = 1'b1;
            free_d      = addr_q;
          end
          if (way_q == WayW'(NUM_WAYS - 1)) begin
            if (have_free_q || !rd_vld_q) begin
              mem_we     = 1'b1;
              mem_waddr  = have_free_q ? free_q : addr_q;
              mem_wdata  = fresh;
              vmem_we    = 1'b1;
              vmem_waddr = mem_waddr;
              vmem_wdata = 1'b1;
              res_d      = to_result(StCreated, fresh);
            end else begin
              res_d = zero_result(StFull);
            end
            state_d = SDone;
          end else begin
            way_d   = way_q + WayW'(1);
            addr_d  = addr_q + AddrW'(1);
            state_d = SWait;
          end
        end
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      have_free_q <= 1'b0;
      lifetime_q  <= LifetimeReset;
      idle_q      <= IdleReset;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      have_free_q <= have_free_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == RegLifetime) begin
          lifetime_q <= cfg_data_i;
        end else begin
          idle_q <= cfg_data_i;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      item_q <= in_i;
    end
    addr_q <= addr_d;
    free_q <= free_d;
    way_q  <= way_d;
    hash_q <= hash_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // flow memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      vmem_q[vmem_waddr] <= vmem_wdata;
    end
    rd_vld_q <= vmem_q[addr_q];
  end

endmodule
